// ===== rtl/mfu_pkg.sv =====
// package for the mfu page frame table unit
// field widths, function codes and the control/status structs shared by the modules
// no dependencies
`timescale 1ns / 1ps

package mfu_pkg;

    // fixed widths of the item and result fields
    localparam int FUNC_W  = 1;
    localparam int PID_W   = 8;
    localparam int PAGE_W  = 10;
    localparam int FRAME_W = 7;
    localparam int COUNT_W = 16;
    localparam int REL_W   = 8;
    localparam int TOTAL_W = 32;

    localparam logic [REL_W-1:0]   REL_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_REFERENCE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE   = 1'b1;

    // sequencer to scan unit
    typedef struct packed {
        logic start;     // new item accepted, clear the trackers
        logic step;      // read data of one frame is present
        logic free_all;  // item frees the frames of a process
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic hit_found;
        logic free_found;
        logic rel_match;  // current frame is valid and owned by the item's process
    } t_scan_stat;

endpackage

// ===== rtl/mfu_frame_ram.sv =====
// frame table storage: one write port, one read port with registered read data
// no dependencies
`timescale 1ns / 1ps

module mfu_frame_ram #(
    parameter int DEPTH,
    parameter int ADDR_W,
    parameter int DATA_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mfu_scan_unit.sv =====
// shared compare unit: looks at one frame per cycle and tracks the first hit,
// the first free frame, the highest-count frame and the release count
// depends on mfu_pkg
`timescale 1ns / 1ps

module mfu_scan_unit import mfu_pkg::*; #(
    parameter int IDX_W,
    parameter int PID_BITS,
    parameter int PAGE_BITS,
    parameter int COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_scan_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic                  i_valid,
    input  logic [PID_BITS-1:0]   i_owner,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [COUNT_BITS-1:0] i_uses,
    input  logic [PID_BITS-1:0]   i_key_pid,
    input  logic [PAGE_BITS-1:0]  i_key_page,
    output t_scan_stat            o_stat,
    output logic [IDX_W-1:0]      o_hit_idx,
    output logic [COUNT_BITS-1:0] o_hit_uses,
    output logic [IDX_W-1:0]      o_free_idx,
    output logic [IDX_W-1:0]      o_best_idx,
    output logic [PID_BITS-1:0]   o_best_owner,
    output logic [PAGE_BITS-1:0]  o_best_page,
    output logic [COUNT_BITS-1:0] o_best_uses,
    output logic [REL_W-1:0]      o_rel_cnt
);

    logic                  r_hit_found;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_uses;
    logic [IDX_W-1:0]      r_free_idx;
    logic [IDX_W-1:0]      r_best_idx;
    logic [PID_BITS-1:0]   r_best_owner;
    logic [PAGE_BITS-1:0]  r_best_page;
    logic [COUNT_BITS-1:0] r_best_uses;
    logic [REL_W-1:0]      r_rel_cnt;

    logic owner_eq;
    logic hit_now;
    logic free_now;
    logic best_now;
    logic rel_match;

    assign owner_eq  = (i_owner == i_key_pid);
    assign hit_now   = i_ctl.step && i_valid && owner_eq && (i_page == i_key_page)
                       && !r_hit_found;
    assign free_now  = i_ctl.step && !i_valid && !r_free_found;
    // first frame seeds the maximum, later ones replace it only when strictly larger
    assign best_now  = i_ctl.step && ((i_idx == '0) || (i_uses > r_best_uses));
    assign rel_match = i_ctl.step && i_valid && owner_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_rel_cnt    <= '0;
        end else if (i_ctl.start) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_rel_cnt    <= '0;
        end else begin
            if (hit_now) begin
                r_hit_found <= 1'b1;
            end
            if (free_now) begin
                r_free_found <= 1'b1;
            end
            if (i_ctl.free_all && rel_match && (r_rel_cnt != REL_MAX)) begin
                r_rel_cnt <= r_rel_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit_now) begin
            r_hit_idx  <= i_idx;
            r_hit_uses <= i_uses;
        end
        if (free_now) begin
            r_free_idx <= i_idx;
        end
        if (best_now) begin
            r_best_idx   <= i_idx;
            r_best_owner <= i_owner;
            r_best_page  <= i_page;
            r_best_uses  <= i_uses;
        end
    end

    assign o_stat.hit_found  = r_hit_found;
    assign o_stat.free_found = r_free_found;
    assign o_stat.rel_match  = rel_match;
    assign o_hit_idx         = r_hit_idx;
    assign o_hit_uses        = r_hit_uses;
    assign o_free_idx        = r_free_idx;
    assign o_best_idx        = r_best_idx;
    assign o_best_owner      = r_best_owner;
    assign o_best_page       = r_best_page;
    assign o_best_uses       = r_best_uses;
    assign o_rel_cnt         = r_rel_cnt;

endmodule

// ===== rtl/mfu_page_frame_table_unit.sv =====
// top level of the mfu page frame table: sequencer, frame ram and scan unit
// depends on mfu_pkg, mfu_frame_ram and mfu_scan_unit
`timescale 1ns / 1ps

// Most-frequently-used page frame table. Every item walks the whole frame table
// once through a single compare unit, one frame per cycle. An item is accepted,
// walks the table behind the registered ram read, and then reaches an update state
// that, for a reference, writes the chosen frame back, and that loads the result
// register. A reference hits on the first valid frame with the same process and
// page and bumps its saturating count; a miss fills the lowest free frame with
// count 1, or when the table is full evicts the frame with the highest count
// (lowest frame on ties). A release frees every frame of a process during the
// walk. The result register lets the next item be taken while a result still
// waits; an item only stalls in its update state if the previous result has not
// been taken. After reset the block clears every frame of the table and takes
// no item until that pass is done.

module mfu_page_frame_table_unit import mfu_pkg::*; #(
    parameter int NUM_FRAMES = 128,
    parameter int PID_BITS   = 8,
    parameter int PAGE_BITS  = 10,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [PID_W-1:0]   i_process_id,
    input  logic [PAGE_W-1:0]  i_page_number,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic               o_evicted,
    output logic [PID_W-1:0]   o_evicted_process,
    output logic [PAGE_W-1:0]  o_evicted_page,
    output logic [COUNT_W-1:0] o_evicted_count,
    output logic [REL_W-1:0]   o_released_frames,
    output logic [TOTAL_W-1:0] o_swap_total,
    output logic [TOTAL_W-1:0] o_hit_total
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int ENT_W = 1 + PID_BITS + PAGE_BITS + COUNT_BITS;
    localparam logic [IDX_W:0] CNT_END  = (IDX_W + 1)'(NUM_FRAMES);
    localparam logic [IDX_W:0] CNT_LAST = (IDX_W + 1)'(NUM_FRAMES - 1);
    localparam logic [COUNT_BITS-1:0] USES_MAX = '1;
    localparam logic [COUNT_BITS-1:0] USES_ONE = COUNT_BITS'(1);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // latched item
    logic [FUNC_W-1:0]    r_func;
    logic [PID_BITS-1:0]  r_pid;
    logic [PAGE_BITS-1:0] r_page;

    // walk counter, one wider than the index so it can hold NUM_FRAMES
    logic [IDX_W:0]   r_cnt;
    logic             r_step_vld;
    logic [IDX_W-1:0] r_step_idx;

    logic [TOTAL_W-1:0] r_swap_total;
    logic [TOTAL_W-1:0] r_hit_total;

    // result register
    logic               r_out_valid;
    logic               r_hit;
    logic [FRAME_W-1:0] r_frame_index;
    logic               r_evicted;
    logic [PID_W-1:0]   r_ev_pid;
    logic [PAGE_W-1:0]  r_ev_page;
    logic [COUNT_W-1:0] r_ev_count;
    logic [REL_W-1:0]   r_released;

    // ram ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [ENT_W-1:0] ram_rdata;

    // unpacked read entry: {valid, owner, page, uses}
    logic                  ent_valid;
    logic [PID_BITS-1:0]   ent_owner;
    logic [PAGE_BITS-1:0]  ent_page;
    logic [COUNT_BITS-1:0] ent_uses;

    t_scan_ctl             scan_ctl;
    t_scan_stat            scan_stat;
    logic [IDX_W-1:0]      hit_idx;
    logic [COUNT_BITS-1:0] hit_uses;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      best_idx;
    logic [PID_BITS-1:0]   best_owner;
    logic [PAGE_BITS-1:0]  best_page;
    logic [COUNT_BITS-1:0] best_uses;
    logic [REL_W-1:0]      rel_cnt;

    logic                  in_xfer;
    logic                  slot_free;
    logic                  result_load;
    logic                  is_release;
    logic                  do_hit;
    logic                  do_evict;
    logic [IDX_W-1:0]      target_idx;
    logic [COUNT_BITS-1:0] new_uses;
    logic [TOTAL_W-1:0]    n_swap_total;
    logic [TOTAL_W-1:0]    n_hit_total;

    assign {ent_valid, ent_owner, ent_page, ent_uses} = ram_rdata;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    assign is_release = (r_func == FUNC_RELEASE);
    assign do_hit     = !is_release && scan_stat.hit_found;
    // evict only when the walk saw no free frame
    assign do_evict   = !is_release && !scan_stat.hit_found && !scan_stat.free_found;
    assign target_idx = scan_stat.hit_found  ? hit_idx :
                        scan_stat.free_found ? free_idx : best_idx;
    assign new_uses   = do_hit ? ((hit_uses == USES_MAX) ? hit_uses : hit_uses + 1'b1)
                               : USES_ONE;

    // saturating totals after this item
    always_comb begin
        n_swap_total = r_swap_total;
        n_hit_total  = r_hit_total;
        if (!is_release) begin
            if (do_hit) begin
                if (r_hit_total != TOTAL_MAX) begin
                    n_hit_total = r_hit_total + 1'b1;
                end
            end else if (r_swap_total != TOTAL_MAX) begin
                n_swap_total = r_swap_total + 1'b1;
            end
        end
    end

    // read one frame per cycle while walking
    assign ram_re = (r_state == ST_SCAN) && (r_cnt < CNT_END);

    // sequencer and ram write port
    always_comb begin
        n_state           = r_state;
        ram_we            = 1'b0;
        ram_waddr         = '0;
        ram_wdata         = '0;
        result_load       = 1'b0;
        scan_ctl.start    = 1'b0;
        scan_ctl.step     = 1'b0;
        scan_ctl.free_all = is_release;
        case (r_state)
            ST_CLEAR: begin
                // clearing pass: one frame per cycle marked free
                ram_we    = 1'b1;
                ram_waddr = r_cnt[IDX_W-1:0];
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    scan_ctl.start = 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_ctl.step = r_step_vld;
                // release frees matching frames behind the read pointer
                if (is_release && scan_stat.rel_match) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_step_idx;
                end
                if ((r_cnt == CNT_END) && r_step_vld) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (slot_free) begin
                    result_load = 1'b1;
                    n_state     = ST_IDLE;
                    if (!is_release) begin
                        ram_we    = 1'b1;
                        ram_waddr = target_idx;
                        ram_wdata = {1'b1, r_pid, r_page, new_uses};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_cnt        <= '0;
            r_step_vld   <= 1'b0;
            r_swap_total <= '0;
            r_hit_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step_vld <= ram_re;
            if (r_state == ST_CLEAR) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (in_xfer) begin
                r_cnt <= '0;
            end else if (ram_re) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (result_load) begin
                r_swap_total <= n_swap_total;
                r_hit_total  <= n_hit_total;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func <= i_func;
            r_pid  <= PID_BITS'(i_process_id);
            r_page <= PAGE_BITS'(i_page_number);
        end
        r_step_idx <= r_cnt[IDX_W-1:0];
        if (result_load) begin
            r_hit         <= do_hit;
            r_frame_index <= is_release ? '0 : FRAME_W'(target_idx);
            r_evicted     <= do_evict;
            r_ev_pid      <= do_evict ? PID_W'(best_owner) : '0;
            r_ev_page     <= do_evict ? PAGE_W'(best_page) : '0;
            r_ev_count    <= do_evict ? COUNT_W'(best_uses) : '0;
            r_released    <= is_release ? rel_cnt : '0;
        end
    end

    mfu_frame_ram #(
        .DEPTH  (NUM_FRAMES),
        .ADDR_W (IDX_W),
        .DATA_W (ENT_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    mfu_scan_unit #(
        .IDX_W      (IDX_W),
        .PID_BITS   (PID_BITS),
        .PAGE_BITS  (PAGE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan_unit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_idx        (r_step_idx),
        .i_valid      (ent_valid),
        .i_owner      (ent_owner),
        .i_page       (ent_page),
        .i_uses       (ent_uses),
        .i_key_pid    (r_pid),
        .i_key_page   (r_page),
        .o_stat       (scan_stat),
        .o_hit_idx    (hit_idx),
        .o_hit_uses   (hit_uses),
        .o_free_idx   (free_idx),
        .o_best_idx   (best_idx),
        .o_best_owner (best_owner),
        .o_best_page  (best_page),
        .o_best_uses  (best_uses),
        .o_rel_cnt    (rel_cnt)
    );

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_hit;
    assign o_frame_index     = r_frame_index;
    assign o_evicted         = r_evicted;
    assign o_evicted_process = r_ev_pid;
    assign o_evicted_page    = r_ev_page;
    assign o_evicted_count   = r_ev_count;
    assign o_released_frames = r_released;
    assign o_swap_total      = r_swap_total;
    assign o_hit_total       = r_hit_total;

`ifndef SYNTH
    // the table is only written by the clearing pass, a release walk or an update
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("frame table written while idle");

    // a result never reports both a hit and an eviction or release
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (!o_evicted && (o_released_frames == '0)))
        else $error("hit result carries eviction or release data");

    // once the update issues its result the block is ready again
    a_update_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result_load |=> o_in_ready)
        else $error("block not ready after update");

    // the running totals never move backward
    a_totals_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_hit_total >= $past(r_hit_total))
                            && (r_swap_total >= $past(r_swap_total))))
        else $error("running total decreased");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for mfu_page_frame_table_unit: directed and random page traffic
// in four throttle phases, checked against an in-bench model of the frame table
// depends on mfu_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;
    import mfu_pkg::*;

    localparam int FRAMES        = 128;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [COUNT_W-1:0] USES_SAT = '1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } t_page_access;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               evicted;
        logic [PID_W-1:0]   ev_pid;
        logic [PAGE_W-1:0]  ev_page;
        logic [COUNT_W-1:0] ev_count;
        logic [REL_W-1:0]   released;
        logic [TOTAL_W-1:0] swaps;
        logic [TOTAL_W-1:0] hits;
    } t_frame_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [FUNC_W-1:0]  i_func = FUNC_REFERENCE;
    logic [PID_W-1:0]   i_process_id = '0;
    logic [PAGE_W-1:0]  i_page_number = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_hit;
    logic [FRAME_W-1:0] o_frame_index;
    logic               o_evicted;
    logic [PID_W-1:0]   o_evicted_process;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [COUNT_W-1:0] o_evicted_count;
    logic [REL_W-1:0]   o_released_frames;
    logic [TOTAL_W-1:0] o_swap_total;
    logic [TOTAL_W-1:0] o_hit_total;

    mfu_page_frame_table_unit #(
        .NUM_FRAMES (FRAMES)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_process_id      (i_process_id),
        .i_page_number     (i_page_number),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_hit             (o_hit),
        .o_frame_index     (o_frame_index),
        .o_evicted         (o_evicted),
        .o_evicted_process (o_evicted_process),
        .o_evicted_page    (o_evicted_page),
        .o_evicted_count   (o_evicted_count),
        .o_released_frames (o_released_frames),
        .o_swap_total      (o_swap_total),
        .o_hit_total       (o_hit_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the frame table
    logic               tbl_valid [FRAMES];
    logic [PID_W-1:0]   tbl_owner [FRAMES];
    logic [PAGE_W-1:0]  tbl_page  [FRAMES];
    logic [COUNT_W-1:0] tbl_uses  [FRAMES];
    logic [TOTAL_W-1:0] model_swaps;
    logic [TOTAL_W-1:0] model_hits;

    t_page_access  staged_q[$];        // whole planned traffic
    t_page_access  access_backlog_q[$]; // traffic released to the driver
    t_frame_result awaited_results_q[$];
    t_page_access  cur_access;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int gap_left = 0;
    int error_count = 0;
    int checked_count = 0;
    int seen_hits = 0;
    int seen_evictions = 0;
    int seen_releases = 0;
    int cycle_count = 0;

    function automatic void clear_frame(int f);
        tbl_valid[f] = 1'b0;
        tbl_owner[f] = '0;
        tbl_page[f]  = '0;
        tbl_uses[f]  = '0;
    endfunction

    function automatic void clear_table();
        for (int f = 0; f < FRAMES; f++) clear_frame(f);
        model_swaps = '0;
        model_hits  = '0;
    endfunction

    function automatic t_frame_result lookup_and_update_frames(t_page_access acc);
        t_frame_result res;
        int slot;
        int best;
        logic found;
        logic free_found;
        res = '0;
        slot = 0;
        found = 1'b0;
        free_found = 1'b0;
        if (acc.func == FUNC_RELEASE) begin
            for (int f = 0; f < FRAMES; f++) begin
                if (tbl_valid[f] && tbl_owner[f] == acc.pid) begin
                    clear_frame(f);
                    if (res.released != REL_MAX) res.released = res.released + 1'b1;
                end
            end
        end else begin
            for (int f = 0; f < FRAMES && !found; f++) begin
                if (tbl_valid[f] && tbl_owner[f] == acc.pid && tbl_page[f] == acc.page) begin
                    found = 1'b1;
                    slot = f;
                end
            end
            if (found) begin
                res.hit = 1'b1;
                if (tbl_uses[slot] != USES_SAT) tbl_uses[slot] = tbl_uses[slot] + 1'b1;
                if (model_hits != TOTAL_MAX) model_hits = model_hits + 1'b1;
            end else begin
                for (int f = 0; f < FRAMES && !free_found; f++) begin
                    if (!tbl_valid[f]) begin
                        free_found = 1'b1;
                        slot = f;
                    end
                end
                if (!free_found) begin
                    // full table: highest count goes, lowest frame on ties
                    best = 0;
                    for (int f = 1; f < FRAMES; f++)
                        if (tbl_uses[f] > tbl_uses[best]) best = f;
                    res.evicted  = 1'b1;
                    res.ev_pid   = tbl_owner[best];
                    res.ev_page  = tbl_page[best];
                    res.ev_count = tbl_uses[best];
                    clear_frame(best);
                    slot = best;
                end
                tbl_valid[slot] = 1'b1;
                tbl_owner[slot] = acc.pid;
                tbl_page[slot]  = acc.page;
                tbl_uses[slot]  = COUNT_W'(1);
                if (model_swaps != TOTAL_MAX) model_swaps = model_swaps + 1'b1;
            end
            res.frame = FRAME_W'(slot);
        end
        res.swaps = model_swaps;
        res.hits  = model_hits;
        return res;
    endfunction

    function automatic t_page_access make_access(logic [FUNC_W-1:0] func, int pid, int page);
        t_page_access acc;
        acc.func = func;
        acc.pid  = PID_W'(pid);
        acc.page = PAGE_W'(page);
        return acc;
    endfunction

    function automatic int pick_resident_frame();
        int f;
        do f = $urandom_range(FRAMES - 1); while (!tbl_valid[f]);
        return f;
    endfunction

    // plans all traffic against a scratch run of the model, so that the random
    // part can aim at resident pages and at a full table; the model is cleared after
    task automatic plan_traffic(output int directed_count);
        t_page_access acc;
        t_frame_result scratch;
        logic [PID_W-1:0] busy_pid [8];
        int resident;
        int roll;
        int hot_frame;
        clear_table();
        hot_frame = 0;
        busy_pid[0] = '0;
        busy_pid[1] = '1;
        for (int k = 2; k < 8; k++) busy_pid[k] = PID_W'($urandom_range(254, 1));

        // process zero and the field extremes, hits, release of an unknown
        // process, release with a page attached, reuse of the lowest free frame
        staged_q.push_back(make_access(FUNC_REFERENCE, 0, 0));
        staged_q.push_back(make_access(FUNC_REFERENCE, 0, 0));
        staged_q.push_back(make_access(FUNC_REFERENCE, 255, 1023));
        staged_q.push_back(make_access(FUNC_REFERENCE, 255, 0));
        staged_q.push_back(make_access(FUNC_REFERENCE, 0, 1023));
        staged_q.push_back(make_access(FUNC_REFERENCE, 255, 1023));
        staged_q.push_back(make_access(FUNC_REFERENCE, 0, 0));
        staged_q.push_back(make_access(FUNC_RELEASE, 77, 0));
        staged_q.push_back(make_access(FUNC_RELEASE, 0, 1023));
        staged_q.push_back(make_access(FUNC_REFERENCE, 'h55, 'h2aa));
        staged_q.push_back(make_access(FUNC_REFERENCE, 'haa, 'h155));
        staged_q.push_back(make_access(FUNC_RELEASE, 255, 'h3ff));
        staged_q.push_back(make_access(FUNC_RELEASE, 255, 0));
        staged_q.push_back(make_access(FUNC_REFERENCE, 'haa, 'h155));
        staged_q.push_back(make_access(FUNC_REFERENCE, 0, 0));
        directed_count = staged_q.size();
        foreach (staged_q[k]) scratch = lookup_and_update_frames(staged_q[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            resident = 0;
            for (int f = 0; f < FRAMES; f++) if (tbl_valid[f]) resident++;
            roll = $urandom_range(99);
            acc = make_access(FUNC_REFERENCE, int'(busy_pid[$urandom_range(7)]),
                              $urandom_range(1023));
            if (resident < FRAMES) begin
                // filling up: mostly new pages, a few hits
                if (roll < 2) begin
                    acc.func = FUNC_RELEASE;
                end else if (roll < 16 && resident != 0) begin
                    hot_frame = pick_resident_frame();
                    acc.pid  = tbl_owner[hot_frame];
                    acc.page = tbl_page[hot_frame];
                end
            end else begin
                if (roll < 6) begin
                    acc.func = FUNC_RELEASE;
                    acc.pid  = tbl_owner[pick_resident_frame()];
                end else if (roll < 8) begin
                    // noise: release of an arbitrary process
                    acc.func = FUNC_RELEASE;
                    acc.pid  = PID_W'($urandom_range(255));
                end else if (roll < 48) begin
                    // hits, leaning on one frame to build a high count
                    if (!tbl_valid[hot_frame] || $urandom_range(3) != 0)
                        hot_frame = pick_resident_frame();
                    acc.pid  = tbl_owner[hot_frame];
                    acc.page = tbl_page[hot_frame];
                end else if (roll < 55) begin
                    acc.pid = PID_W'($urandom_range(255));
                end
                // otherwise a new page of a busy process, which evicts
            end
            staged_q.push_back(acc);
            scratch = lookup_and_update_frames(acc);
        end
        clear_table();
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= 40) $display("[%0t] mismatch: %0s", $time, what);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %0s got 0x%0h expected 0x%0h",
                                      checked_count, name, got, want));
    endtask

    // driver: one transfer in at a time, predicted when it is taken
    always @(posedge i_clk) begin : drive_accesses
        logic taken;
        logic launch;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            taken = i_in_valid && o_in_ready;
            if (taken) begin
                awaited_results_q.push_back(lookup_and_update_frames(cur_access));
                // occasional long gap so that new items land on every part of the walk
                if (src_idle_pct != 0 && $urandom_range(9) == 0)
                    gap_left = $urandom_range(260, 1);
            end else if (gap_left != 0) begin
                gap_left--;
            end
            if (!i_in_valid || taken) begin
                launch = access_backlog_q.size() != 0 && gap_left == 0 &&
                         $urandom_range(99) >= src_idle_pct;
                if (launch) begin
                    cur_access = access_backlog_q.pop_front();
                    i_func        <= cur_access.func;
                    i_process_id  <= cur_access.pid;
                    i_page_number <= cur_access.page;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: every result transfer against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results_q.size() == 0) begin
                    report_mismatch("result transfer with no item outstanding");
                end else begin
                    want = awaited_results_q.pop_front();
                    compare_field("hit", o_hit, want.hit);
                    compare_field("frame_index", o_frame_index, want.frame);
                    compare_field("evicted", o_evicted, want.evicted);
                    compare_field("evicted_process", o_evicted_process, want.ev_pid);
                    compare_field("evicted_page", o_evicted_page, want.ev_page);
                    compare_field("evicted_count", o_evicted_count, want.ev_count);
                    compare_field("released_frames", o_released_frames, want.released);
                    compare_field("swap_total", o_swap_total, want.swaps);
                    compare_field("hit_total", o_hit_total, want.hits);
                    checked_count++;
                    if (want.hit) seen_hits++;
                    if (want.evicted) seen_evictions++;
                    if (want.released != 0) seen_releases++;
                end
            end
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : run_phases
        int directed_count;
        int next_idx;
        int phase_stop;
        int src_pct [4];
        int sink_pct [4];
        src_pct  = '{0, 86, 0, 10};
        sink_pct = '{0, 0, 86, 10};
        plan_traffic(directed_count);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        next_idx = 0;
        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            phase_stop = directed_count + (p + 1) * PHASE_ITEMS;
            while (next_idx < phase_stop && next_idx < staged_q.size()) begin
                access_backlog_q.push_back(staged_q[next_idx]);
                next_idx++;
            end
            // sender holds off until the table has drained its results;
            // checked away from the rising edge so the driver has settled
            while (access_backlog_q.size() != 0 || i_in_valid ||
                   awaited_results_q.size() != 0)
                @(negedge i_clk);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("checked %0d results over four throttle phases: %0d hits, %0d evictions,",
                 checked_count, seen_hits, seen_evictions);
        $display("%0d releases that freed frames, %0d mismatches", seen_releases, error_count);
        if (error_count == 0 && awaited_results_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mfu_pkg.sv
rtl/mfu_frame_ram.sv
rtl/mfu_scan_unit.sv
rtl/mfu_page_frame_table_unit.sv
bench/testbench.sv
